### hdl/cpic_pkg.sv
package cpic_pkg;

   // table and cache geometry
   localparam int unsigned CACHE_DEPTH = 256;
   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned CACHE_AW    = $clog2(CACHE_DEPTH);
   localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned ID_W    = 8;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned MAP_W   = 9;
   localparam int unsigned ENTRY_W = CP_W + ID_W;

   // hash fold distance
   localparam int unsigned HASH_SHIFT = 10;

   // csr port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_ID   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSENT_ID = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_SIZE  = 2'd2;

   localparam logic [ID_W-1:0] PAGE_ID_RST   = 8'h00;
   localparam logic [ID_W-1:0] ABSENT_ID_RST = 8'hff;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_LOOKUP   = 2'd0;
   localparam logic [FUNC_W-1:0] FN_PREFETCH = 2'd1;
   localparam logic [FUNC_W-1:0] FN_MARK     = 2'd2;
   localparam logic [FUNC_W-1:0] FN_LOAD     = 2'd3;

endpackage

### hdl/cpic_if.sv
// request channel
interface cpic_req_if;
   import cpic_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [CP_W-1:0]   code_point;
   logic [SLOT_W-1:0] entry_slot;
   logic [CP_W-1:0]   entry_value;

   modport source (output valid, func, code_point, entry_slot, entry_value, input ready);
   modport sink   (input valid, func, code_point, entry_slot, entry_value, output ready);
endinterface

// response channel
interface cpic_rsp_if;
   import cpic_pkg::*;
   logic              valid;
   logic              ready;
   logic              found;
   logic [SLOT_W-1:0] slot;
   logic              marked_absent;
   logic [ID_W-1:0]   cached_page;

   modport source (output valid, found, slot, marked_absent, cached_page, input ready);
   modport sink   (input valid, found, slot, marked_absent, cached_page, output ready);
endinterface

### hdl/cpic_ram.sv
module cpic_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/code_page_index_cache_unit.sv
// Code point to table position lookup for one code page. A request carries
// one of four operations: lookup, prefetch (peek at the page id in the
// hashed cache entry), mark absent, and load of one sorted table entry.
// The cache is direct mapped, indexed by the low bits of cp xor (cp >> 10),
// and comes out of reset empty (per-entry valid bits, no clearing pass).
// One request is handled at a time: prefetch, mark absent and load
// pass through the check and done states on their way to the output
// register; a lookup that hits the cache, or finds an absent mark, also
// passes the hit state; a lookup that misses adds one compare state
// visit per binary search step on the table memory port, at most 9 steps
// for a 256-entry table. A found point is written into the cache.
// A finished response waits in an output register, so a new request is
// taken while the previous response is still pending.
// Configuration registers must be written only while no request is in flight; the block does not enforce this.
module code_page_index_cache_unit (
   input  logic                          clock,
   input  logic                          reset,
   cpic_req_if.sink                      req_ch,
   cpic_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [cpic_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cpic_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cpic_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_HIT  = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // control and config registers
   logic [2:0]          state_ff, state_in;
   logic [ID_W-1:0]     page_id_ff, absent_id_ff;
   logic [MAP_W-1:0]    map_size_ff;
   logic [CACHE_DEPTH-1:0] cache_vld_ff, cache_vld_in;
   logic                vld_rd_ff, vld_rd_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request payload
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [CP_W-1:0]     cp_ff, cp_in;
   logic [SLOT_W-1:0]   eslot_ff, eslot_in;
   logic [CP_W-1:0]     evalue_ff, evalue_in;
   logic [CACHE_AW-1:0] hash_ff, hash_in;

   // search bounds
   logic [CNT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;

   // pending result and output register
   logic                res_found_ff, res_found_in, res_absent_ff, res_absent_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [ID_W-1:0]     res_page_ff, res_page_in;
   logic                out_found_ff, out_found_in, out_absent_ff, out_absent_in;
   logic [SLOT_W-1:0]   out_slot_ff, out_slot_in;
   logic [ID_W-1:0]     out_page_ff, out_page_in;

   // memory ports
   logic                cache_we, cache_re;
   logic [CACHE_AW-1:0] cache_raddr;
   logic [ENTRY_W-1:0]  cache_wdata, cache_rdata;
   logic                tbl_we;
   logic [TABLE_AW-1:0] tbl_raddr;
   logic [CP_W-1:0]     tbl_rdata;

   // decoded cache entry and shared search step
   logic                req_xfer;
   logic [CP_W-1:0]     req_fold;
   logic [ENTRY_W-1:0]  entry;
   logic [ID_W-1:0]     epage;
   logic [CP_W-1:0]     eidx;
   logic [CNT_W-1:0]    used_size;
   logic                is_absent_mark, is_hit;
   logic [CNT_W-1:0]    nlo, nhi, nmid;
   logic [CNT_W:0]      bound_sum;
   logic                step_go;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // cache index of the incoming point
   assign req_fold    = req_ch.code_point ^ (req_ch.code_point >> HASH_SHIFT);
   assign cache_raddr = req_fold[CACHE_AW-1:0];
   assign cache_re    = req_xfer;

   // entry as read at transfer; an entry never written reads as zero
   assign entry = vld_rd_ff ? cache_rdata : '0;
   assign epage = entry[ID_W-1:0];
   assign eidx  = entry[ENTRY_W-1:ID_W];

   // map size clamped to table depth
   assign used_size = (map_size_ff > MAP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(map_size_ff);

   assign is_absent_mark = (epage == absent_id_ff) && (eidx == cp_ff);
   assign is_hit = (epage == page_id_ff) && (eidx < CP_W'(used_size)) &&
                   (tbl_rdata == cp_ff);

   // next bounds for the search step
   always_comb begin
      nlo = lo_ff;
      nhi = hi_ff;
      if (state_ff == S_HIT) begin
         nlo = '0;
         nhi = used_size;
      end else if (tbl_rdata < cp_ff) begin
         nlo = mid_ff + CNT_W'(1);
      end else begin
         nhi = mid_ff;
      end
   end

   assign bound_sum = {1'b0, nlo} + {1'b0, nhi};
   assign nmid      = bound_sum[CNT_W:1];
   assign step_go   = (nlo < nhi);

   // table read address: cached slot first, then search midpoints
   assign tbl_raddr = (state_ff == S_CHK) ? eidx[TABLE_AW-1:0] : nmid[TABLE_AW-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      cp_in         = cp_ff;
      eslot_in      = eslot_ff;
      evalue_in     = evalue_ff;
      hash_in       = hash_ff;
      vld_rd_in     = vld_rd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      res_absent_in = res_absent_ff;
      res_page_in   = res_page_ff;
      cache_we      = 1'b0;
      cache_wdata   = {cp_ff, absent_id_ff};
      tbl_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               func_in   = req_ch.func;
               cp_in     = req_ch.code_point;
               eslot_in  = req_ch.entry_slot;
               evalue_in = req_ch.entry_value;
               hash_in   = cache_raddr;
               vld_rd_in = cache_vld_ff[cache_raddr];
               state_in  = S_CHK;
            end
         end
         S_CHK: begin
            res_found_in  = 1'b0;
            res_slot_in   = '0;
            res_absent_in = 1'b0;
            res_page_in   = '0;
            state_in      = S_DONE;
            case (func_ff)
               FN_LOOKUP: begin
                  state_in = S_HIT;
               end
               FN_PREFETCH: begin
                  res_page_in   = epage;
                  res_absent_in = is_absent_mark;
               end
               FN_MARK: begin
                  cache_we = 1'b1;
               end
               default: begin
                  tbl_we = ({1'b0, eslot_ff} < CNT_W'(TABLE_DEPTH));
               end
            endcase
         end
         S_HIT: begin
            if (is_hit) begin
               res_found_in = 1'b1;
               res_slot_in  = eidx[SLOT_W-1:0];
               state_in     = S_DONE;
            end else if (is_absent_mark) begin
               res_absent_in = 1'b1;
               state_in      = S_DONE;
            end else if (step_go) begin
               lo_in    = nlo;
               hi_in    = nhi;
               mid_in   = nmid;
               state_in = S_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CMP: begin
            if (tbl_rdata == cp_ff) begin
               cache_we     = 1'b1;
               cache_wdata  = {CP_W'(mid_ff[TABLE_AW-1:0]), page_id_ff};
               res_found_in = 1'b1;
               res_slot_in  = SLOT_W'(mid_ff[TABLE_AW-1:0]);
               state_in     = S_DONE;
            end else if (step_go) begin
               lo_in  = nlo;
               hi_in  = nhi;
               mid_in = nmid;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // cache valid bits
   always_comb begin
      cache_vld_in = cache_vld_ff;
      if (cache_we) begin
         cache_vld_in[hash_ff] = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      out_found_in  = out_found_ff;
      out_slot_in   = out_slot_ff;
      out_absent_in = out_absent_ff;
      out_page_in   = out_page_ff;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in  = 1'b1;
         out_found_in  = res_found_ff;
         out_slot_in   = res_slot_ff;
         out_absent_in = res_absent_ff;
         out_page_in   = res_page_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cache_vld_ff <= '0;
         vld_rd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cache_vld_ff <= cache_vld_in;
         vld_rd_ff    <= vld_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_id_ff   <= PAGE_ID_RST;
         absent_id_ff <= ABSENT_ID_RST;
         map_size_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAGE_ID:   page_id_ff   <= csr_wdata[ID_W-1:0];
            CSR_ABSENT_ID: absent_id_ff <= csr_wdata[ID_W-1:0];
            CSR_MAP_SIZE:  map_size_ff  <= csr_wdata[MAP_W-1:0];
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      cp_ff         <= cp_in;
      eslot_ff      <= eslot_in;
      evalue_ff     <= evalue_in;
      hash_ff       <= hash_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      res_absent_ff <= res_absent_in;
      res_page_ff   <= res_page_in;
      out_found_ff  <= out_found_in;
      out_slot_ff   <= out_slot_in;
      out_absent_ff <= out_absent_in;
      out_page_ff   <= out_page_in;
   end

   // lookup cache: slot or code point over page id
   cpic_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CACHE_DEPTH)
   ) u_cache (
      .clock (clock),
      .we    (cache_we),
      .waddr (hash_ff),
      .wdata (cache_wdata),
      .re    (cache_re),
      .raddr (cache_raddr),
      .rdata (cache_rdata)
   );

   // sorted code table
   cpic_ram #(
      .WIDTH (CP_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (eslot_ff[TABLE_AW-1:0]),
      .wdata (evalue_ff),
      .re    (1'b1),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = out_found_ff;
   assign rsp_ch.slot          = out_slot_ff;
   assign rsp_ch.marked_absent = out_absent_ff;
   assign rsp_ch.cached_page   = out_page_ff;

   // a response is never both found and absent
   a_found_not_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.found && rsp_ch.marked_absent))
      else $error("response both found and marked absent");

   // slot is zero unless found
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.found) |-> (rsp_ch.slot == '0))
      else $error("nonzero slot on a miss");

   // search window stays open and inside the table while stepping
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> ((lo_ff <= mid_ff) && (mid_ff < hi_ff) &&
                               (hi_ff <= used_size)))
      else $error("search bounds out of order");

   // the cache is only written while a request is being worked on
   a_cache_write_busy: assert property (@(posedge clock) disable iff (reset)
      cache_we |-> ((state_ff == S_CHK && func_ff == FN_MARK) ||
                    (state_ff == S_CMP && func_ff == FN_LOOKUP)))
      else $error("unexpected cache write");

endmodule

### sim/code_page_index_cache_unit_test.sv
module code_page_index_cache_unit_test;
   import cpic_pkg::*;

   localparam int unsigned CP_MAX = 'h10FFFF;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CP_W-1:0]   code_point;
      logic [SLOT_W-1:0] entry_slot;
      logic [CP_W-1:0]   entry_value;
   } page_request_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic              marked_absent;
      logic [ID_W-1:0]   cached_page;
   } page_answer_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cpic_req_if req_bus ();
   cpic_rsp_if rsp_bus ();

   code_page_index_cache_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // requests waiting to be offered and answers waiting to come back
   page_request_type pending_requests[$];
   page_answer_type  expected_answers[$];
   page_request_type offered;
   int unsigned   mismatches = 0;
   bit            steady = 1'b0;

   // predicted block state
   logic [ID_W-1:0]  cfg_page;
   logic [ID_W-1:0]  cfg_absent;
   logic [MAP_W-1:0] cfg_map;
   logic [CP_W-1:0]  code_mem [TABLE_DEPTH];
   logic [CP_W-1:0]  cache_key [CACHE_DEPTH];
   logic [ID_W-1:0]  cache_page [CACHE_DEPTH];

   // stimulus-side view of the table and of recent absent marks
   int unsigned plan_mem [TABLE_DEPTH];
   int unsigned planned_marks[$];

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      cfg_page = PAGE_ID_RST;
      cfg_absent = ABSENT_ID_RST;
      cfg_map = '0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         cache_key[i] = '0;
         cache_page[i] = '0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         code_mem[i] = '0;
         plan_mem[i] = 0;
      end
   end

   // expected answer for one request, updating table and cache as the block does
   function automatic page_answer_type predict_answer(page_request_type r);
      logic [CACHE_AW-1:0] h;
      logic [CP_W-1:0]     key;
      logic [ID_W-1:0]     pg;
      int unsigned         used, lo, hi, mid;
      page_answer_type     a;
      h = CACHE_AW'(r.code_point ^ (r.code_point >> HASH_SHIFT));
      key = cache_key[h];
      pg = cache_page[h];
      used = (cfg_map > TABLE_DEPTH) ? TABLE_DEPTH : cfg_map;
      a = '0;
      case (r.func)
         FN_LOOKUP: begin
            if (pg == cfg_page && key < used && code_mem[key[TABLE_AW-1:0]] == r.code_point) begin
               a.found = 1'b1;
               a.slot = key[SLOT_W-1:0];
            end else if (pg == cfg_absent && key == r.code_point) begin
               a.marked_absent = 1'b1;
            end else begin
               // binary search over the used part of the table
               lo = 0;
               hi = used;
               while (lo < hi && !a.found) begin
                  mid = (lo + hi) / 2;
                  if (code_mem[mid] == r.code_point) begin
                     cache_key[h] = CP_W'(mid);
                     cache_page[h] = cfg_page;
                     a.found = 1'b1;
                     a.slot = SLOT_W'(mid);
                  end else if (code_mem[mid] < r.code_point) begin
                     lo = mid + 1;
                  end else begin
                     hi = mid;
                  end
               end
            end
         end
         FN_PREFETCH: begin
            a.cached_page = pg;
            a.marked_absent = (pg == cfg_absent && key == r.code_point);
         end
         FN_MARK: begin
            cache_key[h] = r.code_point;
            cache_page[h] = cfg_absent;
         end
         default: begin
            code_mem[r.entry_slot] = r.entry_value;
         end
      endcase
      return a;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // request driver: predicts each accepted transfer, then offers the next item
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.func <= FN_LOOKUP;
         req_bus.code_point <= '0;
         req_bus.entry_slot <= '0;
         req_bus.entry_value <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_answers.push_back(predict_answer(offered));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
               offered = pending_requests.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.func <= offered.func;
               req_bus.code_point <= offered.code_point;
               req_bus.entry_slot <= offered.entry_slot;
               req_bus.entry_value <= offered.entry_value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response ready: random gaps plus two long hold-offs
   int unsigned hold_left;
   int unsigned rsp_taken;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
         rsp_taken <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            rsp_taken <= rsp_taken + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.valid && rsp_bus.ready && (rsp_taken == 99 || rsp_taken == 299)) begin
            hold_left <= 250;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || $urandom_range(0, 99) >= 29;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      page_answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("response transfer with nothing outstanding");
         end else begin
            want = expected_answers.pop_front();
            check_field("found", rsp_bus.found, want.found);
            check_field("slot", rsp_bus.slot, want.slot);
            check_field("marked_absent", rsp_bus.marked_absent, want.marked_absent);
            check_field("cached_page", rsp_bus.cached_page, want.cached_page);
         end
      end
   end

   // stimulus helpers
   task automatic queue_item(input logic [FUNC_W-1:0] f, input int unsigned cp,
                             input int unsigned eslot, input int unsigned evalue);
      page_request_type r;
      r.func = f;
      r.code_point = CP_W'(cp);
      r.entry_slot = SLOT_W'(eslot);
      r.entry_value = CP_W'(evalue);
      pending_requests.push_back(r);
      if (f == FN_LOAD)
         plan_mem[r.entry_slot] = r.entry_value;
      if (f == FN_MARK) begin
         planned_marks.push_back(r.code_point);
         if (planned_marks.size() > 32)
            void'(planned_marks.pop_front());
      end
   endtask

   // another point that lands on the same cache entry
   function automatic int unsigned collide(input int unsigned cp, input int unsigned d);
      int unsigned c;
      c = cp ^ (d << HASH_SHIFT) ^ d;
      return (c > CP_MAX) ? cp : c;
   endfunction

   function automatic int unsigned pick_point(input int unsigned used);
      int unsigned k, c;
      k = $urandom_range(0, 99);
      if (used != 0 && k < 55)
         c = plan_mem[$urandom_range(0, used - 1)];
      else if (k < 75 && planned_marks.size() != 0)
         c = planned_marks[$urandom_range(0, planned_marks.size() - 1)];
      else
         c = $urandom_range(0, CP_MAX);
      if ($urandom_range(0, 4) == 0)
         c = collide(c, $urandom_range(1, 255));
      return c;
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_bus.valid || expected_answers.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      case (idx)
         CSR_PAGE_ID:   cfg_page = d[ID_W-1:0];
         CSR_ABSENT_ID: cfg_absent = d[ID_W-1:0];
         default:       cfg_map = d[MAP_W-1:0];
      endcase
   endtask

   // one setting: program registers, reload part of the table, then random traffic
   task automatic run_phase(input logic [ID_W-1:0] pg, input logic [ID_W-1:0] ab,
                            input logic [MAP_W-1:0] ms, input int unsigned fresh,
                            input int unsigned spread, input bit falling,
                            input int unsigned count);
      int unsigned v, step, used, k, i;
      used = (ms > TABLE_DEPTH) ? TABLE_DEPTH : ms;
      write_reg(CSR_PAGE_ID, CSR_DATA_W'(pg));
      write_reg(CSR_ABSENT_ID, CSR_DATA_W'(ab));
      write_reg(CSR_MAP_SIZE, ms);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      // table contents, ascending unless a falling table is wanted
      v = falling ? CP_MAX - $urandom_range(0, 50) : $urandom_range(0, 2000);
      for (i = 0; i < fresh; i++) begin
         queue_item(FN_LOAD, $urandom_range(0, CP_MAX), i, v);
         step = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, spread);
         if (falling)
            v = (v > step) ? v - step : 0;
         else
            v = (CP_MAX - v > step) ? v + step : CP_MAX;
      end
      for (i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         if (k < 45)
            queue_item(FN_LOOKUP, pick_point(used), $urandom_range(0, 255),
                       $urandom_range(0, CP_MAX));
         else if (k < 62)
            queue_item(FN_PREFETCH, pick_point(used), $urandom_range(0, 255),
                       $urandom_range(0, CP_MAX));
         else if (k < 80)
            queue_item(FN_MARK, pick_point(used), $urandom_range(0, 255),
                       $urandom_range(0, CP_MAX));
         else
            queue_item(FN_LOAD, $urandom_range(0, CP_MAX), $urandom_range(0, 255),
                       pick_point(used));
      end
      wait_drained();
   endtask

   // main sequence
   initial begin
      csr_we = 1'b0;
      csr_index = CSR_PAGE_ID;
      csr_wdata = '0;
      @(negedge reset);
      @(negedge clock);

      // directed checks with the reset settings and an empty table in use
      queue_item(FN_LOOKUP, 0, 255, CP_MAX);
      queue_item(FN_LOOKUP, CP_MAX, 0, 0);
      queue_item(FN_PREFETCH, 0, 0, 0);
      queue_item(FN_MARK, CP_MAX, 0, 0);
      queue_item(FN_PREFETCH, CP_MAX, 0, 0);
      queue_item(FN_LOOKUP, CP_MAX, 0, 0);
      queue_item(FN_MARK, collide(CP_MAX, 1), 0, 0);
      queue_item(FN_PREFETCH, CP_MAX, 0, 0);
      queue_item(FN_LOOKUP, collide(CP_MAX, 1), 0, 0);
      queue_item(FN_LOAD, CP_MAX, 0, 0);
      queue_item(FN_LOAD, 0, 255, CP_MAX);
      queue_item(FN_LOAD, 'h0AAAAA, 170, 'h0F0000);
      queue_item(FN_LOAD, 'h055555, 85, 'h0AAAAA);
      queue_item(FN_MARK, 0, 0, 0);
      queue_item(FN_PREFETCH, 0, 0, 0);
      queue_item(FN_LOOKUP, 0, 0, 0);
      wait_drained();

      run_phase(8'h5a, 8'hff, 9'd16, 16, 3, 1'b0, 30);
      // full table with no idling on either side
      steady = 1'b1;
      run_phase(8'hff, 8'h00, 9'd256, 256, 4000, 1'b0, 30);
      steady = 1'b0;
      // page id equal to the absent id
      run_phase(8'h5a, 8'h5a, 9'd40, 10, 40, 1'b0, 20);
      // map size beyond the table, treated as the full table
      run_phase(8'h00, 8'hff, 9'd511, 0, 1, 1'b0, 20);
      // unsorted table
      run_phase(8'h33, 8'hc0, 9'd24, 24, 500, 1'b1, 10);
      run_phase(8'h81, 8'h7e, 9'd1, 1, 1, 1'b0, 8);
      run_phase(8'ha5, 8'h00, 9'd0, 0, 1, 1'b0, 6);
      run_phase($urandom_range(0, 255), $urandom_range(0, 255), 9'd120, 0, 900, 1'b0, 8);

      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("code_page_index_cache_unit verification clean");
      end else begin
         $display("code_page_index_cache_unit verification failed");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #2000000;
      $display("code_page_index_cache_unit verification failed");
      $finish;
   end

endmodule
